/* rtl/qph_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qph_pkg
// Shared types and constants for the quadratic probing hash table.
// ----------------------------------------------------------------------------
package qph_pkg;

    localparam int TABLE_SIZE   = 16;
    localparam int SLOT_W       = $clog2(TABLE_SIZE);
    localparam int CNT_W        = SLOT_W + 1;
    localparam int KEY_W        = 16;
    localparam int SLOT_FIELD_W = 4;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_FOUND    = 2'd2,
        STAT_MISSING  = 2'd3
    } status_t;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic [SLOT_FIELD_W-1:0] slot;
    } rsp_t;

    // completion report from the probe engine
    typedef struct packed {
        logic valid;
        rsp_t rsp;
    } done_t;

    // key store access
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_data;
    } ram_req_t;

endpackage
`default_nettype wire

/* rtl/qph_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qph_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module qph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* rtl/qph_probe.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qph_probe
// Probe sequencer: walks home + i*i, holds the slot valid bits, drives the
// key store and compares returned keys one probe behind the issue.
// ----------------------------------------------------------------------------
module qph_probe
    import qph_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    input  wire req_t             req,
    output logic                  req_ready,
    input  wire logic             out_free,
    output done_t                 done,
    output ram_req_t              ram_req,
    input  wire logic [KEY_W-1:0] rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_PROBE = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic                    kind_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [SLOT_W-1:0]       home_reg;
    logic [SLOT_W-1:0]       off_reg, off_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    pend_reg, pend_next;
    logic [SLOT_W-1:0]       pslot_reg, pslot_next;
    logic [TABLE_SIZE-1:0]   valid_reg, valid_next;

    logic [SLOT_W-1:0]       probe_s;
    logic                    hit;
    logic                    accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign probe_s   = home_reg + off_reg;
    assign hit       = pend_reg && (rd_data == key_reg);

    always_comb
    begin
        state_next       = state_reg;
        off_next         = off_reg;
        cnt_next         = cnt_reg;
        pend_next        = pend_reg;
        pslot_next       = pslot_reg;
        valid_next       = valid_reg;
        done             = '0;
        done.rsp.status  = STAT_INSERTED;
        ram_req          = '0;
        ram_req.rd_addr  = probe_s;
        ram_req.wr_addr  = probe_s;
        ram_req.wr_data  = key_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PROBE;
                    off_next   = '0;
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                end
            end
            ST_PROBE:
            begin
                if (out_free)
                begin
                    // earlier probe's compare takes priority over the current probe
                    priority if (hit)
                    begin
                        done.valid      = 1'b1;
                        done.rsp.status = STAT_FOUND;
                        done.rsp.slot   = SLOT_FIELD_W'(pslot_reg);
                        state_next      = ST_IDLE;
                    end
                    else if (cnt_reg == CNT_W'(TABLE_SIZE))
                    begin
                        done.valid      = 1'b1;
                        done.rsp.status = (kind_reg == KIND_INSERT) ? STAT_FULL
                                                                    : STAT_MISSING;
                        state_next      = ST_IDLE;
                    end
                    else if (!valid_reg[probe_s])
                    begin
                        done.valid = 1'b1;
                        state_next = ST_IDLE;
                        if (kind_reg == KIND_INSERT)
                        begin
                            done.rsp.status     = STAT_INSERTED;
                            done.rsp.slot       = SLOT_FIELD_W'(probe_s);
                            ram_req.wr_en       = 1'b1;
                            valid_next[probe_s] = 1'b1;
                        end
                        else
                        begin
                            done.rsp.status = STAT_MISSING;
                        end
                    end
                    else
                    begin
                        if (kind_reg == KIND_SEARCH)
                        begin
                            ram_req.rd_en = 1'b1;
                            pend_next     = 1'b1;
                            pslot_next    = probe_s;
                        end
                        // (i+1)^2 = i^2 + 2i + 1
                        off_next = off_reg + SLOT_W'({cnt_reg, 1'b1});
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
            off_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            off_reg   <= off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pslot_reg <= pslot_next;
        if (accept)
        begin
            kind_reg <= req.kind;
            key_reg  <= req.key;
            home_reg <= req.key[SLOT_W-1:0];
        end
    end

endmodule
`default_nettype wire

/* rtl/quadratic_probe_hash_table.sv */
`default_nettype none
// Response: registered from the probe engine's completion report. A search
// compares each key store read one probe behind the issue; a spent sequence is
// reported once all TABLE_SIZE probes are used. Probing pauses while a
// response waits. Requests are taken one at a time, the next once probing ends.
// Reset: all slots empty at once (valid bits cleared); key store not cleared.
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressed key table with quadratic probing, insert and search requests.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table
    import qph_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    done_t            done;
    ram_req_t         ram_req;
    logic [KEY_W-1:0] rd_data;
    logic             out_free;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    qph_probe u_probe (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready),
        .out_free  (out_free),
        .done      (done),
        .ram_req   (ram_req),
        .rd_data   (rd_data)
    );

    qph_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_key_store (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (done.valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done.valid)
        begin
            rsp_reg <= done.rsp;
        end
    end

endmodule
`default_nettype wire

/* rtl/qph_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qph_checker
// Port-level checks on the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module qph_checker
    import qph_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // no slot reported on a miss or a full table
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STAT_FULL || rsp.status == STAT_MISSING)
        |-> rsp.slot == '0)
        else $error("slot set on miss or full");

    // one request in flight: ready drops after an accepted request
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another in flight");

    // a new response only follows probe work, never an idle cycle
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response appeared without a request in flight");

endmodule

bind quadratic_probe_hash_table qph_checker u_qph_checker (.*);
`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadratic probing hash table. Insert and search
// requests are driven through a valid/ready port. A mirror of the table in the
// bench predicts every response, and responses are checked in order. The
// stimulus is a directed run, a back-to-back burst, a long response stall and
// a long random run.
// ----------------------------------------------------------------------------
module tb_top;
    import qph_pkg::*;

    localparam int RST_CYCLES  = 7;
    localparam int GAP_MAX     = 18;
    localparam int HOLD_CYCLES = 150;
    localparam int WDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS = 10;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // mirror of the table contents
    logic [KEY_W-1:0] mirror_key [TABLE_SIZE];
    logic             mirror_used [TABLE_SIZE];

    rsp_t             pending_rsp_q [$];
    logic [KEY_W-1:0] stored_keys [$];

    int src_gap_max;
    int snk_gap_max;
    int rsp_hold_cycles;
    int err_cnt;
    int rsp_cnt;
    int insert_cnt;
    int search_cnt;
    int status_cnt [4];

    quadratic_probe_hash_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Walks the probe sequence on the mirror and updates it as the block should.
    function automatic rsp_t probe_table(input logic kind, input logic [KEY_W-1:0] key);
        rsp_t res;
        int   home;
        int   s;
        bit   stop;
        home       = int'(key) % TABLE_SIZE;
        stop       = 1'b0;
        res.status = (kind == KIND_INSERT) ? STAT_FULL : STAT_MISSING;
        res.slot   = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            s = (home + i * i) % TABLE_SIZE;
            if (!stop)
            begin
                if (kind == KIND_INSERT)
                begin
                    if (!mirror_used[s])
                    begin
                        mirror_used[s] = 1'b1;
                        mirror_key[s]  = key;
                        res.status     = STAT_INSERTED;
                        res.slot       = SLOT_FIELD_W'(s);
                        stop           = 1'b1;
                    end
                end
                else if (!mirror_used[s])
                begin
                    stop = 1'b1;
                end
                else if (mirror_key[s] == key)
                begin
                    res.status = STAT_FOUND;
                    res.slot   = SLOT_FIELD_W'(s);
                    stop       = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Leaves req_valid high after acceptance; the next call either replaces the
    // payload in the same step or lowers valid for its gap.
    task automatic send_op(input logic kind, input logic [KEY_W-1:0] key);
        req_t item;
        rsp_t want;
        int   gap;
        item.kind = kind;
        item.key  = key;
        gap       = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        want = probe_table(kind, key);
        pending_rsp_q.push_back(want);
        status_cnt[want.status]++;
        if (kind == KIND_INSERT)
        begin
            insert_cnt++;
            if (want.status == STAT_INSERTED)
                stored_keys.push_back(key);
        end
        else
        begin
            search_cnt++;
        end
    endtask

    task automatic end_burst();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_ops(input int n);
        int               r;
        logic [KEY_W-1:0] key;
        for (int k = 0; k < n; k++)
        begin
            r   = $urandom_range(0, 99);
            key = KEY_W'($urandom_range(0, 65535));
            if (r < 35)
            begin
                // some inserts repeat a key already held
                if (r < 8 && stored_keys.size() != 0)
                    key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                send_op(KIND_INSERT, key);
            end
            else
            begin
                if (r < 80 && stored_keys.size() != 0)
                    key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                send_op(KIND_SEARCH, key);
            end
        end
    endtask

    task automatic test_directed();
        src_gap_max = GAP_MAX;
        snk_gap_max = GAP_MAX;
        send_op(KIND_SEARCH, 16'h0000);     // empty table
        send_op(KIND_INSERT, 16'h0000);
        send_op(KIND_INSERT, 16'hFFFF);
        send_op(KIND_SEARCH, 16'hFFFF);
        send_op(KIND_SEARCH, 16'h0000);
        send_op(KIND_INSERT, 16'h0010);     // collides at home 0
        send_op(KIND_INSERT, 16'h0010);     // duplicate goes further along
        send_op(KIND_SEARCH, 16'h0010);     // earliest copy wins
        send_op(KIND_INSERT, 16'h0020);
        send_op(KIND_INSERT, 16'h0030);     // home 0 sequence exhausted, table not full
        send_op(KIND_SEARCH, 16'h0040);     // all probes used, no match
        send_op(KIND_SEARCH, 16'h0001);     // stops at an empty slot
        send_op(KIND_SEARCH, 16'h8000);
        send_op(KIND_INSERT, 16'h8001);
        send_op(KIND_SEARCH, 16'h8001);
        send_op(KIND_INSERT, 16'h7FFE);
        send_op(KIND_INSERT, 16'hAAAA);
        send_op(KIND_INSERT, 16'h5555);
        send_op(KIND_SEARCH, 16'h5555);
        send_op(KIND_SEARCH, 16'h5554);
        end_burst();
    endtask

    task automatic test_back_to_back();
        src_gap_max = 0;
        snk_gap_max = 0;
        random_ops(300);
        end_burst();
    endtask

    task automatic test_rsp_stall();
        src_gap_max     = 0;
        snk_gap_max     = 0;
        rsp_hold_cycles = HOLD_CYCLES;
        random_ops(16);
        end_burst();
    endtask

    task automatic test_random();
        src_gap_max = GAP_MAX;
        snk_gap_max = GAP_MAX;
        random_ops(1100);
        end_burst();
    endtask

    // response side: ready pattern and in-order check
    initial
    begin : rsp_side
        int   gap;
        int   held;
        rsp_t want;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                held = 0;
                while (held < rsp_hold_cycles)
                begin
                    @(posedge clk);
                    held++;
                end
                rsp_hold_cycles = 0;
            end
            gap = $urandom_range(0, snk_gap_max);
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            rsp_cnt++;
            if (pending_rsp_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("ERROR: response with nothing pending: status %0d slot %0d",
                             rsp.status, rsp.slot);
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                if (rsp.status !== want.status || rsp.slot !== want.slot)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("ERROR: response %0d: status exp %0d got %0d, slot exp %0d got %0d",
                                 rsp_cnt, want.status, rsp.status, want.slot, rsp.slot);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid === 1'b1 && req_ready === 1'b1) ||
                (rsp_valid === 1'b1 && rsp_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WDOG_LIMIT)
            begin
                $display("ERROR: no handshake for %0d cycles, %0d responses pending",
                         quiet, pending_rsp_q.size());
                $display("** quadratic_probe_hash_table: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin : main
        err_cnt         = 0;
        rsp_cnt         = 0;
        insert_cnt      = 0;
        search_cnt      = 0;
        rsp_hold_cycles = 0;
        src_gap_max     = 0;
        snk_gap_max     = 0;
        for (int s = 0; s < 4; s++)
            status_cnt[s] = 0;
        for (int s = 0; s < TABLE_SIZE; s++)
        begin
            mirror_used[s] = 1'b0;
            mirror_key[s]  = '0;
        end
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_back_to_back();
        test_rsp_stall();
        test_random();

        // let any stray response show up before the verdict
        repeat (TABLE_SIZE + 4) @(posedge clk);
        if (pending_rsp_q.size() != 0)
        begin
            err_cnt++;
            $display("ERROR: %0d responses never arrived", pending_rsp_q.size());
        end
        $display("Run covered %0d inserts and %0d searches, %0d responses checked, %0d errors.",
                 insert_cnt, search_cnt, rsp_cnt, err_cnt);
        $display("Outcomes: %0d inserted, %0d full, %0d found, %0d not found.",
                 status_cnt[STAT_INSERTED], status_cnt[STAT_FULL],
                 status_cnt[STAT_FOUND], status_cnt[STAT_MISSING]);
        if (err_cnt == 0)
            $display("** quadratic_probe_hash_table: PASSED **");
        else
            $display("** quadratic_probe_hash_table: FAILED **");
        $finish;
    end

endmodule
